FILE: src/rwg_pkg.sv
// Shared types and constants for the Ricker wavelet sample generator.
// No dependencies; imported by the generator top level and its checker.
package rwg_pkg;

   localparam int RWG_MAX_SAMPLES = 4096;

   localparam int TIME_STEP_W = 24;
   localparam int PEAK_FREQ_W = 16;
   localparam int DELAY_W     = 12;
   localparam int COUNT_W     = 13;
   localparam int INDEX_W     = 12;
   localparam int AMP_W       = 16;
   localparam int CSR_DATA_W  = 24;

   localparam logic [TIME_STEP_W-1:0] TIME_STEP_RST = 24'd16777;
   localparam logic [PEAK_FREQ_W-1:0] PEAK_FREQ_RST = 16'd7680;
   localparam logic [DELAY_W-1:0]     DELAY_RST     = 12'd0;
   localparam logic [COUNT_W-1:0]     COUNT_RST     = 13'd1024;

   // pi^2 in Q.16
   localparam logic [19:0] PI_SQ_Q16 = 20'd646814;
   localparam logic [24:0] ONE_Q24   = 25'h100_0000;

   // Taylor steps of exp(-f) and pipeline depth from start to result strobe
   localparam int EXP_STEPS   = 8;
   localparam int RWG_LATENCY = 27;

   typedef enum logic [1:0] {
      CSR_TIME_STEP,
      CSR_PEAK_FREQ,
      CSR_DELAY,
      CSR_COUNT
   } csr_index_type;

   // exp(-n) in Q.24 for n = 0..15
   localparam logic [24:0] EXP_INT_TABLE [16] = '{
      25'd16777216, 25'd6171993, 25'd2270549, 25'd835288,
      25'd307285,   25'd113044,  25'd41587,   25'd15299,
      25'd5628,     25'd2070,    25'd762,     25'd280,
      25'd103,      25'd38,      25'd14,      25'd5
   };

   typedef struct packed {
      logic valid;
      logic oor;
      logic zero;
   } ctl_type;

   typedef struct packed {
      ctl_type     ctl;
      logic        neg;
      logic [20:0] smag;
      logic [3:0]  exp_int;
      logic [23:0] frac;
   } side_type;

endpackage

FILE: src/ricker_wavelet_generator_unit.sv
// Ricker wavelet sample generator: fixed-point pipeline from sample index to amplitude.
// Depends on rwg_pkg for register defaults, the exp(-n) table and stage sideband types.

// One transaction enters per clock: busy is always low, so start is taken every cycle it
// is high. Each transaction produces exactly one result, strobed by rsp_valid for a single
// cycle; the receiver cannot stall, and results come out in request order. The 27 register
// stages are: distance and range check, two multiplies for the scaled time, rounding, two
// multiplies for u = (pi*fr*t)^2, the (1 - 2u) term, eight two-stage steps of the exp(-frac)
// polynomial (multiply, then divide by a constant through a reciprocal multiply), the integer
// exp table product and its rounding, the final product and the saturating output stage.
// Register writes on the csr_ port take effect at once and must only happen while no
// transaction is in flight.
module ricker_wavelet_generator_unit
   import rwg_pkg::*;
#(
   parameter int MAX_SAMPLES = RWG_MAX_SAMPLES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [INDEX_W-1:0]      req_sample_index,
   output logic                    rsp_valid,
   output logic signed [AMP_W-1:0] rsp_amplitude,
   output logic                    rsp_index_out_of_range,
   input  logic                    csr_write_enable,
   input  logic [1:0]              csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data
);

   localparam int LEN_W = $clog2(MAX_SAMPLES + 1);
   localparam int CMP_W = (LEN_W > COUNT_W) ? LEN_W : COUNT_W;
   localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_SAMPLES);

   // ---------------- configuration registers ----------------
   logic [TIME_STEP_W-1:0] time_step_ff;
   logic [PEAK_FREQ_W-1:0] peak_freq_ff;
   logic [DELAY_W-1:0]     delay_ff;
   logic [COUNT_W-1:0]     count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RST;
         peak_freq_ff <= PEAK_FREQ_RST;
         delay_ff     <= DELAY_RST;
         count_ff     <= COUNT_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_TIME_STEP: time_step_ff <= csr_write_data[TIME_STEP_W-1:0];
            CSR_PEAK_FREQ: peak_freq_ff <= csr_write_data[PEAK_FREQ_W-1:0];
            CSR_DELAY:     delay_ff     <= csr_write_data[DELAY_W-1:0];
            CSR_COUNT:     count_ff     <= csr_write_data[COUNT_W-1:0];
         endcase
      end
   end

   assign busy = 1'b0;

   // ---------------- stage 1: distance from peak, range check ----------------
   logic [CMP_W-1:0]   len;
   logic [DELAY_W-1:0] dist_in;
   ctl_type            s1_ctl_in;
   logic [DELAY_W-1:0] dist_ff;
   ctl_type            s1_ctl_ff;

   always_comb begin
      len = (CMP_W'(count_ff) > MAX_LEN) ? MAX_LEN : CMP_W'(count_ff);
      if (req_sample_index >= delay_ff) begin
         dist_in = req_sample_index - delay_ff;
      end else begin
         dist_in = delay_ff - req_sample_index;
      end
      s1_ctl_in.valid = start && !busy;
      s1_ctl_in.oor   = CMP_W'(req_sample_index) >= len;
      s1_ctl_in.zero  = 1'b0;
   end

   // ---------------- stages 2..6: scaled time and u ----------------
   logic [35:0] dts_in, dts_ff;
   logic [51:0] p_in, p_ff;
   logic [34:0] p_round;
   logic [17:0] p16_in, p16_ff;
   logic [34:0] sq_in, sq_ff;
   logic [54:0] usc_in, usc_ff;
   ctl_type     s2_ctl_ff, s3_ctl_ff, s4_ctl_ff, s4_ctl_in, s5_ctl_ff, s6_ctl_ff;

   assign dts_in  = 36'(dist_ff) * 36'(time_step_ff);
   assign p_in    = 52'(dts_ff) * 52'(peak_freq_ff);
   assign p_round = 35'(p_ff[33:0]) + 35'd32768;
   assign p16_in  = p_round[33:16];
   assign sq_in   = 35'(36'(p16_ff) * 36'(p16_ff));
   assign usc_in  = 55'(sq_ff) * 55'(PI_SQ_Q16);

   always_comb begin
      s4_ctl_in      = s3_ctl_ff;
      // drop the far tail: p at or above 2.0
      s4_ctl_in.zero = s3_ctl_ff.zero || (|p_ff[51:33]);
   end

   // ---------------- stage 7: u, (1 - 2u) term, exp split ----------------
   localparam int SIDE_N = 2 * EXP_STEPS + 1;

   logic [55:0] u_round;
   logic [23:0] u_full;
   logic [19:0] u_val;
   logic [20:0] two_u;
   side_type    s7_side_in;
   side_type    side_ff [SIDE_N];

   always_comb begin
      u_round              = 56'(usc_ff) + (56'd1 << 31);
      u_full               = u_round[55:32];
      u_val                = u_full[19:0];
      two_u                = {u_val, 1'b0};
      s7_side_in.ctl       = s6_ctl_ff;
      s7_side_in.ctl.zero  = s6_ctl_ff.zero || (|u_full[23:20]);
      s7_side_in.neg       = two_u > 21'd65536;
      if (s7_side_in.neg) begin
         s7_side_in.smag = two_u - 21'd65536;
      end else begin
         s7_side_in.smag = 21'd65536 - two_u;
      end
      s7_side_in.exp_int   = u_val[19:16];
      s7_side_in.frac      = {u_val[15:0], 8'd0};
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      dts_ff  <= dts_in;
      p_ff    <= p_in;
      p16_ff  <= p16_in;
      sq_ff   <= sq_in;
      usc_ff  <= usc_in;
      if (reset) begin
         s1_ctl_ff  <= '0;
         s2_ctl_ff  <= '0;
         s3_ctl_ff  <= '0;
         s4_ctl_ff  <= '0;
         s5_ctl_ff  <= '0;
         s6_ctl_ff  <= '0;
         side_ff[0] <= '0;
      end else begin
         s1_ctl_ff  <= s1_ctl_in;
         s2_ctl_ff  <= s1_ctl_ff;
         s3_ctl_ff  <= s2_ctl_ff;
         s4_ctl_ff  <= s4_ctl_in;
         s5_ctl_ff  <= s4_ctl_ff;
         s6_ctl_ff  <= s5_ctl_ff;
         side_ff[0] <= s7_side_in;
      end
   end

   // ---------------- exp(-frac): q = 1 - f*q/k for k = 8 down to 1 ----------------
   logic [23:0] x_ff [EXP_STEPS];
   logic [24:0] q_ff [EXP_STEPS];

   for (genvar g = 0; g < EXP_STEPS; g++) begin : g_exp
      localparam int unsigned KDIV = EXP_STEPS - g;
      // exact floor(x / KDIV) for x below 2^24
      localparam logic [27:0] RECIP = 28'((64'd1 << 27) / KDIV + 64'd1);

      logic [24:0] q_prev;
      logic [48:0] fq_prod;
      logic [23:0] x_in;
      logic [51:0] div_prod;
      logic [24:0] q_in;

      if (g == 0) begin : g_first
         assign q_prev = ONE_Q24;
      end else begin : g_next
         assign q_prev = q_ff[g-1];
      end

      assign fq_prod  = 49'(side_ff[2*g].frac) * 49'(q_prev);
      assign x_in     = fq_prod[47:24];
      assign div_prod = 52'(x_ff[g]) * 52'(RECIP);
      assign q_in     = ONE_Q24 - 25'(div_prod[50:27]);

      always_ff @(posedge clock) begin
         x_ff[g] <= x_in;
         q_ff[g] <= q_in;
         if (reset) begin
            side_ff[2*g+1] <= '0;
            side_ff[2*g+2] <= '0;
         end else begin
            side_ff[2*g+1] <= side_ff[2*g];
            side_ff[2*g+2] <= side_ff[2*g+1];
         end
      end
   end

   // ---------------- exp table product, final product, saturation ----------------
   logic [49:0] ep_in, ep_ff;
   logic [49:0] ep_round;
   logic [24:0] e_in, e_ff;
   logic [45:0] mp_in, mp_ff;
   logic [46:0] mag_round;
   logic [21:0] mag;
   side_type    e1_side_ff, e2_side_ff, m1_side_ff;

   logic                    rsp_valid_in, rsp_valid_ff;
   logic signed [AMP_W-1:0] amp_in, amp_ff;
   logic                    oor_in, oor_ff;

   assign ep_in     = 50'(EXP_INT_TABLE[side_ff[SIDE_N-1].exp_int])
                      * 50'(q_ff[EXP_STEPS-1]);
   assign ep_round  = ep_ff + (50'd1 << 23);
   assign e_in      = ep_round[48:24];
   assign mp_in     = 46'(e2_side_ff.smag) * 46'(e_ff);
   assign mag_round = 47'(mp_ff) + (47'd1 << 24);
   assign mag       = mag_round[46:25];

   always_comb begin
      rsp_valid_in = m1_side_ff.ctl.valid;
      oor_in       = m1_side_ff.ctl.oor;
      if (m1_side_ff.ctl.oor || m1_side_ff.ctl.zero) begin
         amp_in = '0;
      end else if (m1_side_ff.neg) begin
         if (mag >= 22'd32768) begin
            amp_in = 16'sh8000;
         end else begin
            amp_in = AMP_W'(~mag[AMP_W-1:0] + 16'd1);
         end
      end else begin
         if (mag > 22'd32767) begin
            amp_in = 16'sh7fff;
         end else begin
            amp_in = mag[AMP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      ep_ff  <= ep_in;
      e_ff   <= e_in;
      mp_ff  <= mp_in;
      amp_ff <= amp_in;
      oor_ff <= oor_in;
      if (reset) begin
         e1_side_ff   <= '0;
         e2_side_ff   <= '0;
         m1_side_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         e1_side_ff   <= side_ff[SIDE_N-1];
         e2_side_ff   <= e1_side_ff;
         m1_side_ff   <= e2_side_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_amplitude          = amp_ff;
   assign rsp_index_out_of_range = oor_ff;

endmodule

FILE: src/rwg_checker.sv
// Port-level checks for the Ricker wavelet sample generator, bound to its top level.
// Depends on rwg_pkg for the pipeline latency.
module rwg_checker
   import rwg_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_valid,
   input logic signed [AMP_W-1:0] rsp_amplitude,
   input logic                    rsp_index_out_of_range
);

   // every result traces back to a transaction taken a fixed time earlier
   a_result_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, RWG_LATENCY))
      else $error("result strobe without a matching transaction");

   // every transaction taken outside reset yields a result at the fixed latency
   a_request_gets_result: assert property (@(posedge clock) disable iff (reset)
      $past(start && !busy && !reset, RWG_LATENCY) && !$past(reset, RWG_LATENCY - 1)
      && $stable(reset) && !$past(reset, 1) && !$past(reset, RWG_LATENCY / 2)
      |-> rsp_valid || $past(reset, RWG_LATENCY - 2))
      else $error("transaction lost in the pipeline");

   // an out-of-range index gives a zero amplitude
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_out_of_range |-> rsp_amplitude == '0)
      else $error("out-of-range result with nonzero amplitude");

   // the pipeline can take a transaction in every cycle
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

endmodule

bind ricker_wavelet_generator_unit rwg_checker u_rwg_checker (
   .clock                  (clock),
   .reset                  (reset),
   .start                  (start),
   .busy                   (busy),
   .rsp_valid              (rsp_valid),
   .rsp_amplitude          (rsp_amplitude),
   .rsp_index_out_of_range (rsp_index_out_of_range)
);

FILE: test/tb_top.sv
// Self-checking testbench for ricker_wavelet_generator_unit: drives sample-index requests,
// rewrites the wavelet registers between phases and checks every amplitude and range flag.
// Depends on rwg_pkg for port widths and register index names, and on the unit under test.
module tb_top;
   import rwg_pkg::*;

   // start-to-strobe depth of the block, used with slack for the end-of-run wait
   localparam int PIPE_DEPTH = 27;
   localparam int HALT_TIME  = 400000;

   localparam logic [23:0] RST_TIME_STEP = 24'd16777;
   localparam logic [15:0] RST_PEAK_FREQ = 16'd7680;
   localparam logic [11:0] RST_DELAY     = 12'd0;
   localparam logic [12:0] RST_COUNT     = 13'd1024;
   localparam longint unsigned LEN_CAP   = 4096;
   localparam longint unsigned PI_SQ     = 646814;
   localparam longint unsigned ONE_Q24   = 64'd1 << 24;

   // exp(-n), n = 0..15, in Q.24
   localparam longint unsigned EXP_WHOLE [16] = '{
      16777216, 6171993, 2270549, 835288, 307285, 113044, 41587, 15299,
      5628, 2070, 762, 280, 103, 38, 14, 5
   };

   typedef struct {
      logic signed [AMP_W-1:0] amplitude;
      logic                    out_of_range;
   } wavelet_sample_type;

   logic                    clock;
   logic                    reset;
   logic                    start = 1'b0;
   logic                    busy;
   logic [INDEX_W-1:0]      req_sample_index = '0;
   logic                    rsp_valid;
   logic signed [AMP_W-1:0] rsp_amplitude;
   logic                    rsp_index_out_of_range;
   logic                    csr_write_enable;
   csr_index_type           csr_index;
   logic [CSR_DATA_W-1:0]   csr_write_data;

   logic [INDEX_W-1:0] pending_indices [$];
   wavelet_sample_type expected_samples [$];
   int                 submitted_count = 0;
   int                 accepted_count = 0;
   int                 mismatch_count = 0;
   int                 gap_left = 0;
   bit                 idle_enable = 1'b1;
   logic               took = 1'b0;

   // register shadow used for prediction
   logic [23:0] wav_time_step;
   logic [15:0] wav_peak_freq;
   logic [11:0] wav_delay;
   logic [12:0] wav_count;

   ricker_wavelet_generator_unit DUT (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_sample_index       (req_sample_index),
      .rsp_valid              (rsp_valid),
      .rsp_amplitude          (rsp_amplitude),
      .rsp_index_out_of_range (rsp_index_out_of_range),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data)
   );

   function automatic wavelet_sample_type ricker_sample(input logic [INDEX_W-1:0] idx);
      wavelet_sample_type r;
      longint unsigned    span, offset, prod, p16, u, frac, q, e, smag, mag;
      bit                 neg;
      r.amplitude    = '0;
      r.out_of_range = 1'b0;
      span = (wav_count > LEN_CAP) ? LEN_CAP : wav_count;
      if (idx >= span) begin
         r.out_of_range = 1'b1;
         return r;
      end
      offset = (idx >= wav_delay) ? idx - wav_delay : wav_delay - idx;
      prod = offset * wav_time_step * wav_peak_freq;
      // far tail: fr*t of 2.0 or more rounds to zero
      if (prod >= (64'd1 << 33))
         return r;
      p16 = (prod + (64'd1 << 15)) >> 16;
      u   = (p16 * p16 * PI_SQ + (64'd1 << 31)) >> 32;
      if (u >= (64'd16 << 16))
         return r;
      // exp(-frac) by nested Taylor steps, then scale by exp(-whole)
      frac = (u & 64'hFFFF) << 8;
      q    = ONE_Q24;
      for (longint unsigned k = 8; k >= 1; k--)
         q = ONE_Q24 - ((frac * q) >> 24) / k;
      e = (EXP_WHOLE[u >> 16] * q + (ONE_Q24 >> 1)) >> 24;
      if (2 * u <= 65536) begin
         smag = 65536 - 2 * u;
         neg  = 1'b0;
      end else begin
         smag = 2 * u - 65536;
         neg  = 1'b1;
      end
      mag = (smag * e + (64'd1 << 24)) >> 25;
      if (neg)
         r.amplitude = (mag > 32768) ? -16'sd32768 : 16'(64'd0 - mag);
      else
         r.amplitude = (mag > 32767) ? 16'sd32767 : 16'(mag);
      return r;
   endfunction

   task automatic queue_index(input int idx);
      pending_indices.push_back(INDEX_W'(idx));
      submitted_count++;
   endtask

   // write all four registers; bits above each register's width carry junk
   task automatic load_config(input logic [23:0] ts, input logic [15:0] fr,
                              input logic [11:0] dly, input logic [12:0] cnt);
      logic [23:0] vals [4];
      int          widths [4];
      vals   = '{ts, 24'(fr), 24'(dly), 24'(cnt)};
      widths = '{24, 16, 12, 13};
      for (int r = 0; r < 4; r++) begin
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_index        <= csr_index_type'(r);
         csr_write_data   <= vals[r] | (24'($urandom) << widths[r]);
         @(negedge clock);
         csr_write_enable <= 1'b0;
      end
   endtask

   // hold the sender until every transaction has been taken and answered
   task automatic wait_idle();
      do @(negedge clock);
      while (accepted_count != submitted_count || expected_samples.size() != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // driver: present one index at a time, hold it until taken, then maybe idle
   always @(negedge clock) begin
      if (reset) begin
         start            <= 1'b0;
         req_sample_index <= '0;
         gap_left         <= 0;
      end else if (!start || took) begin
         if (gap_left != 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_indices.size() != 0) begin
            start            <= 1'b1;
            req_sample_index <= pending_indices.pop_front();
            if (idle_enable && $urandom_range(0, 3) == 0)
               gap_left <= $urandom_range(1, 4);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check the strobed result, track register writes, predict taken requests
   always @(posedge clock) begin : monitor
      wavelet_sample_type want;
      if (reset) begin
         took          <= 1'b0;
         wav_time_step = RST_TIME_STEP;
         wav_peak_freq = RST_PEAK_FREQ;
         wav_delay     = RST_DELAY;
         wav_count     = RST_COUNT;
      end else begin
         if (rsp_valid) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected result amplitude %0d flag %0b", $time,
                        rsp_amplitude, rsp_index_out_of_range);
               mismatch_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_amplitude !== want.amplitude) begin
                  $display("%0t: amplitude expected %0d actual %0d", $time,
                           want.amplitude, rsp_amplitude);
                  mismatch_count++;
               end
               if (rsp_index_out_of_range !== want.out_of_range) begin
                  $display("%0t: index_out_of_range expected %0b actual %0b", $time,
                           want.out_of_range, rsp_index_out_of_range);
                  mismatch_count++;
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TIME_STEP: wav_time_step = csr_write_data[23:0];
               CSR_PEAK_FREQ: wav_peak_freq = csr_write_data[15:0];
               CSR_DELAY:     wav_delay     = csr_write_data[11:0];
               CSR_COUNT:     wav_count     = csr_write_data[12:0];
               default: ;
            endcase
         end
         took <= start && !busy;
         if (start && !busy) begin
            expected_samples.push_back(ricker_sample(req_sample_index));
            accepted_count++;
         end
      end
   end

   initial begin
      longint unsigned span, ts, fr;
      int              dly, cnt, off, pos;
      bit              shaped;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_TIME_STEP;
      csr_write_data   = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset values: peak, positive lobe, negative lobe, exp flush, far tail, range edge
      queue_index(0);    queue_index(10);   queue_index(20);   queue_index(30);
      queue_index(38);   queue_index(45);   queue_index(60);   queue_index(70);
      queue_index(1023); queue_index(1024); queue_index(4095);
      wait_idle();

      // peak in the middle, indices on both sides of it
      load_config(24'd16777, 16'd7680, 12'd2000, 13'd4096);
      queue_index(2000); queue_index(1995); queue_index(2005);
      queue_index(0);    queue_index(4095);
      wait_idle();

      // zero time step: flat peak; count above the cap is clipped
      load_config(24'd0, 16'd7680, 12'd100, 13'd8191);
      queue_index(4095); queue_index(17);
      wait_idle();

      // zero frequency with a one-sample wavelet
      load_config(24'hFFFFFF, 16'd0, 12'd0, 13'd1);
      queue_index(0); queue_index(1); queue_index(4095);
      wait_idle();

      // zero count: every index out of range
      load_config(24'd1, 16'hFFFF, 12'd4095, 13'd0);
      queue_index(0); queue_index(4095);
      wait_idle();

      for (int phase = 0; phase < 14; phase++) begin
         idle_enable = (phase < 11);
         shaped      = ($urandom_range(0, 3) != 0);
         dly         = $urandom_range(0, 4095);
         span        = $urandom_range(4, 1000);
         if (shaped) begin
            // size dt so the wavelet spans a few to a thousand samples
            fr  = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 65535) : $urandom_range(1, 4096);
            ts  = (64'd1 << 33) / (span * fr);
            if (ts == 0) ts = 1;
            if (ts > 24'hFFFFFF) ts = 24'hFFFFFF;
            cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) : 4096;
         end else begin
            case ($urandom_range(0, 3))
               0: ts = 1;
               1: ts = 24'hFFFFFF;
               2: ts = 0;
               default: ts = $urandom_range(1, 24'hFFFFFF);
            endcase
            case ($urandom_range(0, 2))
               0: fr = 0;
               1: fr = 16'hFFFF;
               default: fr = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 2))
               0: dly = 0;
               1: dly = 4095;
               default: ;
            endcase
            case ($urandom_range(0, 4))
               0: cnt = 0;
               1: cnt = 1;
               2: cnt = 4096;
               3: cnt = 8191;
               default: cnt = $urandom_range(0, 8191);
            endcase
         end
         load_config(ts[23:0], fr[15:0], dly[11:0], cnt[12:0]);
         for (int n = 0; n < 43; n++) begin
            if (shaped && $urandom_range(0, 3) != 0) begin
               off = $urandom_range(0, int'(span + span / 4));
               pos = ($urandom_range(0, 1) != 0) ? dly + off : dly - off;
               if (pos < 0) pos = 0;
               if (pos > 4095) pos = 4095;
            end else begin
               pos = $urandom_range(0, 4095);
            end
            queue_index(pos);
         end
         wait_idle();
      end

      repeat (PIPE_DEPTH + 8) @(negedge clock);
      if (mismatch_count == 0)
         $display("ricker_wavelet_generator_unit: match");
      else
         $display("ricker_wavelet_generator_unit: mismatch");
      $finish;
   end

   initial begin
      #HALT_TIME;
      $display("ricker_wavelet_generator_unit: mismatch");
      $finish;
   end

endmodule

FILE: filelist.f
src/rwg_pkg.sv
src/ricker_wavelet_generator_unit.sv
src/rwg_checker.sv
test/tb_top.sv
